// ----- hdl/tsmq_pkg.sv -----
// Shared types, constants and the sensor scan order for the timestamp merge of sensor queues.
// No dependencies; every other file in this block but tsmq_ram imports it.
package tsmq_pkg;

    localparam int NUM_Q            = 8;
    localparam int NUM_SENSORS      = 6;
    localparam int SMALL_DEPTH_DEF  = 4;
    localparam int IMU_DEPTH_DEF    = 128;

    localparam int CMD_W    = 2;
    localparam int SRC_W    = 3;
    localparam int FIX_W    = 3;
    localparam int STAMP_W  = 32;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 8;
    localparam int ENTRY_W  = STAMP_W + DATA_W;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DROP   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FILTER = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd3;

    localparam logic [SRC_W-1:0] SRC_BARO = 3'd0;
    localparam logic [SRC_W-1:0] SRC_HUM  = 3'd1;
    localparam logic [SRC_W-1:0] SRC_MAG  = 3'd2;
    localparam logic [SRC_W-1:0] SRC_NAV  = 3'd3;
    localparam logic [SRC_W-1:0] SRC_TIME = 3'd4;
    localparam logic [SRC_W-1:0] SRC_RAW  = 3'd5;
    localparam logic [SRC_W-1:0] SRC_IMU  = 3'd6;
    localparam logic [SRC_W-1:0] SRC_VBAT = 3'd7;

    localparam logic [FIX_W-1:0] FIX_KEPT = 3'd3;

    typedef struct packed {
        logic push;
        logic pop;
        logic drop;
    } t_qupd;

    function automatic logic [SRC_W-1:0] sensor_src(input logic [SRC_W-1:0] k);
        logic [SRC_W-1:0] s;
        case (k)
            3'd0: s = SRC_BARO;
            3'd1: s = SRC_HUM;
            3'd2: s = SRC_MAG;
            3'd3: s = SRC_TIME;
            3'd4: s = SRC_IMU;
            3'd5: s = SRC_VBAT;
            default: s = SRC_BARO;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/tsmq_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module tsmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tsmq_qtab.sv -----
// Per-queue read and write pointers, fill levels and high-water marks.
// Depends on tsmq_pkg.
module tsmq_qtab #(
    parameter int SMALL_DEPTH = tsmq_pkg::SMALL_DEPTH_DEF,
    parameter int IMU_DEPTH   = tsmq_pkg::IMU_DEPTH_DEF,
    parameter int PTR_W       = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tsmq_pkg::SRC_W-1:0]  i_sel,
    input  tsmq_pkg::t_qupd             i_upd,
    output logic [tsmq_pkg::NUM_Q-1:0]  o_nonempty,
    output logic                        o_full,
    output logic [PTR_W-1:0]            o_rd_ptr,
    output logic [PTR_W-1:0]            o_wr_ptr,
    output logic [tsmq_pkg::FILL_W-1:0] o_peak
);
    import tsmq_pkg::*;

    localparam logic [FILL_W-1:0] D_SMALL = FILL_W'(SMALL_DEPTH);
    localparam logic [FILL_W-1:0] D_IMU   = FILL_W'(IMU_DEPTH);

    logic [PTR_W-1:0]  r_rd_ptr [NUM_Q];
    logic [PTR_W-1:0]  r_wr_ptr [NUM_Q];
    logic [FILL_W-1:0] r_fill   [NUM_Q];
    logic [FILL_W-1:0] r_peak   [NUM_Q];

    logic [FILL_W-1:0] depth_sel;
    logic [PTR_W-1:0]  last_sel;
    logic [FILL_W-1:0] fill_sel;
    logic [FILL_W-1:0] n_fill_inc;
    logic [PTR_W-1:0]  n_rd_adv;
    logic [PTR_W-1:0]  n_wr_adv;

    always_comb begin
        depth_sel  = (i_sel == SRC_IMU) ? D_IMU : D_SMALL;
        last_sel   = PTR_W'(depth_sel - 8'd1);
        fill_sel   = r_fill[i_sel];
        n_fill_inc = fill_sel + 8'd1;
        n_rd_adv   = (r_rd_ptr[i_sel] == last_sel) ? '0 : r_rd_ptr[i_sel] + 1'b1;
        n_wr_adv   = (r_wr_ptr[i_sel] == last_sel) ? '0 : r_wr_ptr[i_sel] + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_Q; q++) begin
                r_rd_ptr[q] <= '0;
                r_wr_ptr[q] <= '0;
                r_fill[q]   <= '0;
                r_peak[q]   <= '0;
            end
        end else begin
            if (i_upd.push) begin
                r_wr_ptr[i_sel] <= n_wr_adv;
                r_fill[i_sel]   <= n_fill_inc;
                if (n_fill_inc > r_peak[i_sel]) begin
                    r_peak[i_sel] <= n_fill_inc;
                end
            end
            if (i_upd.drop) begin
                r_peak[i_sel] <= depth_sel;
            end
            if (i_upd.pop) begin
                r_rd_ptr[i_sel] <= n_rd_adv;
                r_fill[i_sel]   <= fill_sel - 8'd1;
            end
        end
    end

    for (genvar g = 0; g < NUM_Q; g++) begin : g_nonempty
        assign o_nonempty[g] = (r_fill[g] != '0);
    end

    assign o_full   = (fill_sel >= depth_sel);
    assign o_rd_ptr = r_rd_ptr[i_sel];
    assign o_wr_ptr = r_wr_ptr[i_sel];
    assign o_peak   = r_peak[i_sel];

endmodule

// ----- hdl/timestamp_merge_sensor_queues.sv -----
// Top level: eight timestamped record queues in one RAM, merged on pop.
// Depends on tsmq_pkg, tsmq_ram and tsmq_qtab.
//
//  Channel  | Beat signals             | Flow control | Contents
//  ---------+--------------------------+--------------+-------------------------------------
//  in       | i_in_valid               | o_in_stall   | command, source, fix, stamp, data
//  out      | o_out_valid              | i_out_stall  | entry, source, stamp, data, status
//  cfg      | i_cfg_wr_en              | none         | raw_enable
//
// A pop takes the raw queue if raw_enable is set and it is non-empty, else the navigation
// queue, else the oldest head of the six sensor queues, read one at a time through the
// single RAM read port with empty queues skipped; on equal stamps the earlier sensor in
// the scan order wins.
// Reset is synchronous and clears pointers, fill levels, marks and the first-fix flag.
// A result waits in the output register while the out channel stalls; the next input
// beat is taken as soon as the block has finished with the previous one.
module timestamp_merge_sensor_queues #(
    parameter int SMALL_QUEUE_DEPTH = tsmq_pkg::SMALL_DEPTH_DEF,
    parameter int IMU_QUEUE_DEPTH   = tsmq_pkg::IMU_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tsmq_pkg::CMD_W-1:0]    i_command,
    input  logic [tsmq_pkg::SRC_W-1:0]    i_source,
    input  logic [tsmq_pkg::FIX_W-1:0]    i_fix_quality,
    input  logic [tsmq_pkg::STAMP_W-1:0]  i_stamp,
    input  logic [tsmq_pkg::DATA_W-1:0]   i_record_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_entry_valid,
    output logic [tsmq_pkg::SRC_W-1:0]    o_out_source,
    output logic [tsmq_pkg::STAMP_W-1:0]  o_out_stamp,
    output logic [tsmq_pkg::DATA_W-1:0]   o_out_data,
    output logic [tsmq_pkg::STATUS_W-1:0] o_status,
    output logic [tsmq_pkg::FILL_W-1:0]   o_high_water,
    output logic                          o_first_fix
);
    import tsmq_pkg::*;

    localparam int MAX_DEPTH   = (SMALL_QUEUE_DEPTH > IMU_QUEUE_DEPTH) ?
                                 SMALL_QUEUE_DEPTH : IMU_QUEUE_DEPTH;
    localparam int PTR_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int STORE_DEPTH = 7 * SMALL_QUEUE_DEPTH + IMU_QUEUE_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] BASE_LAST = ADDR_W'(6 * SMALL_QUEUE_DEPTH + IMU_QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] SMALL_A   = ADDR_W'(SMALL_QUEUE_DEPTH);
    localparam logic [SRC_W-1:0]  K_LAST    = SRC_W'(NUM_SENSORS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HEAD,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SCAN_OUT
    } t_state;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SRC_W-1:0] s,
                                                    input logic [PTR_W-1:0] p);
        logic [ADDR_W-1:0] base;
        base = (s == SRC_VBAT) ? BASE_LAST : ADDR_W'(s) * SMALL_A;
        return base + ADDR_W'(p);
    endfunction

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [SRC_W-1:0]    r_src;
    logic [FIX_W-1:0]    r_fix;
    logic [STAMP_W-1:0]  r_stamp;
    logic [DATA_W-1:0]   r_data;
    logic                r_raw_en;
    logic                r_fix_seen, n_fix_seen;
    logic [SRC_W-1:0]    r_k, n_k;
    logic                r_found, n_found;
    logic [SRC_W-1:0]    r_pick, n_pick;
    logic [STAMP_W-1:0]  r_best_stamp, n_best_stamp;
    logic [DATA_W-1:0]   r_best_data, n_best_data;

    logic                r_out_valid, n_out_valid;
    logic                r_out_entry, n_out_entry;
    logic [SRC_W-1:0]    r_out_src, n_out_src;
    logic [STAMP_W-1:0]  r_out_stamp, n_out_stamp;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [FILL_W-1:0]   r_out_hw, n_out_hw;
    logic                r_out_ffix, n_out_ffix;

    logic                in_accept;
    logic                out_free;
    logic                pick_raw;
    logic                first_nav;
    logic [SRC_W-1:0]    q_sel;
    t_qupd               q_upd;
    logic [NUM_Q-1:0]    q_nonempty;
    logic                q_full;
    logic [PTR_W-1:0]    q_rd_ptr;
    logic [PTR_W-1:0]    q_wr_ptr;
    logic [FILL_W-1:0]   q_peak;

    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [STAMP_W-1:0]  rd_stamp;
    logic [DATA_W-1:0]   rd_data;

    tsmq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_stamp, r_data}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tsmq_qtab #(
        .SMALL_DEPTH (SMALL_QUEUE_DEPTH),
        .IMU_DEPTH   (IMU_QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_qtab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sel      (q_sel),
        .i_upd      (q_upd),
        .o_nonempty (q_nonempty),
        .o_full     (q_full),
        .o_rd_ptr   (q_rd_ptr),
        .o_wr_ptr   (q_wr_ptr),
        .o_peak     (q_peak)
    );

    assign rd_stamp   = ram_rdata[ENTRY_W-1:DATA_W];
    assign rd_data    = ram_rdata[DATA_W-1:0];
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign pick_raw   = r_raw_en && q_nonempty[SRC_RAW];
    assign first_nav  = (r_pick == SRC_NAV) && !r_fix_seen;
    assign ram_waddr  = slot_addr(q_sel, q_wr_ptr);
    assign ram_raddr  = slot_addr(q_sel, q_rd_ptr);

    always_comb begin
        case (r_state)
            S_EXEC: begin
                if (r_cmd == CMD_POP) begin
                    q_sel = pick_raw ? SRC_RAW : SRC_NAV;
                end else begin
                    q_sel = r_src;
                end
            end
            S_HEAD, S_SCAN_OUT:     q_sel = r_pick;
            S_SCAN_RD, S_SCAN_CMP:  q_sel = sensor_src(r_k);
            default:                q_sel = r_src;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_fix_seen   = r_fix_seen;
        n_k          = r_k;
        n_found      = r_found;
        n_pick       = r_pick;
        n_best_stamp = r_best_stamp;
        n_best_data  = r_best_data;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_entry  = r_out_entry;
        n_out_src    = r_out_src;
        n_out_stamp  = r_out_stamp;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_hw     = r_out_hw;
        n_out_ffix   = r_out_ffix;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        q_upd        = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_POP) begin
                    if (pick_raw || q_nonempty[SRC_NAV]) begin
                        ram_re  = 1'b1;
                        n_pick  = q_sel;
                        n_state = S_HEAD;
                    end else begin
                        n_k     = '0;
                        n_found = 1'b0;
                        n_state = S_SCAN_RD;
                    end
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_entry  = 1'b0;
                    n_out_src    = r_src;
                    n_out_stamp  = '0;
                    n_out_data   = '0;
                    n_out_status = STAT_OK;
                    n_out_hw     = '0;
                    n_out_ffix   = 1'b0;
                    n_state      = S_IDLE;
                    case (r_cmd)
                        CMD_PUSH: begin
                            if ((r_src == SRC_NAV && r_fix != FIX_KEPT) ||
                                (r_src == SRC_RAW && !r_raw_en)) begin
                                n_out_status = STAT_FILTER;
                            end else if (q_full) begin
                                n_out_status = STAT_DROP;
                                q_upd.drop   = 1'b1;
                            end else begin
                                ram_we     = 1'b1;
                                q_upd.push = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            n_out_hw = q_peak;
                        end
                        default: begin
                            n_out_src    = '0;
                            n_out_status = STAT_FILTER;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (q_nonempty[q_sel]) begin
                    ram_re  = 1'b1;
                    n_state = S_SCAN_CMP;
                end else if (r_k == K_LAST) begin
                    n_state = S_SCAN_OUT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_SCAN_CMP: begin
                if (!r_found || rd_stamp < r_best_stamp) begin
                    n_found      = 1'b1;
                    n_pick       = q_sel;
                    n_best_stamp = rd_stamp;
                    n_best_data  = rd_data;
                end
                if (r_k == K_LAST) begin
                    n_state = S_SCAN_OUT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_HEAD, S_SCAN_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hw    = '0;
                    n_state     = S_IDLE;
                    if (r_state == S_HEAD || r_found) begin
                        n_out_entry  = 1'b1;
                        n_out_src    = r_pick;
                        n_out_stamp  = (r_state == S_HEAD) ? rd_stamp : r_best_stamp;
                        n_out_data   = (r_state == S_HEAD) ? rd_data : r_best_data;
                        n_out_status = STAT_OK;
                        n_out_ffix   = first_nav;
                        n_fix_seen   = r_fix_seen || first_nav;
                        q_upd.pop    = 1'b1;
                    end else begin
                        n_out_entry  = 1'b0;
                        n_out_src    = '0;
                        n_out_stamp  = '0;
                        n_out_data   = '0;
                        n_out_status = STAT_EMPTY;
                        n_out_ffix   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_raw_en    <= 1'b0;
            r_fix_seen  <= 1'b0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fix_seen  <= n_fix_seen;
            r_k         <= n_k;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_raw_en <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= i_command;
            r_src   <= i_source;
            r_fix   <= i_fix_quality;
            r_stamp <= i_stamp;
            r_data  <= i_record_data;
        end
        r_pick       <= n_pick;
        r_best_stamp <= n_best_stamp;
        r_best_data  <= n_best_data;
        r_out_entry  <= n_out_entry;
        r_out_src    <= n_out_src;
        r_out_stamp  <= n_out_stamp;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_hw     <= n_out_hw;
        r_out_ffix   <= n_out_ffix;
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_valid = r_out_entry;
    assign o_out_source  = r_out_src;
    assign o_out_stamp   = r_out_stamp;
    assign o_out_data    = r_out_data;
    assign o_status      = r_out_status;
    assign o_high_water  = r_out_hw;
    assign o_first_fix   = r_out_ffix;

endmodule

// ----- hdl/tsmq_checker.sv -----
// Port-level checks for the timestamp merge of sensor queues, bound to the top level.
// Depends on tsmq_pkg and timestamp_merge_sensor_queues.
module tsmq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_entry_valid,
    input logic [tsmq_pkg::SRC_W-1:0]    o_out_source,
    input logic [tsmq_pkg::STAMP_W-1:0]  o_out_stamp,
    input logic [tsmq_pkg::DATA_W-1:0]   o_out_data,
    input logic [tsmq_pkg::STATUS_W-1:0] o_status,
    input logic [tsmq_pkg::FILL_W-1:0]   o_high_water,
    input logic                          o_first_fix
);
    import tsmq_pkg::*;

    // Only one beat is worked on at a time, so the input stalls straight after a beat.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_rst_n) |=> o_in_stall)
        else $error("input beat taken while the previous one is still in progress");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_entry_valid) |-> (o_status == STAT_OK && o_high_water == '0))
        else $error("delivered entry carries a non-ok status or a high-water mark");

    a_first_fix_nav: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_first_fix) |-> (o_entry_valid && o_out_source == SRC_NAV))
        else $error("first-fix flag on something other than a navigation entry");

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_EMPTY) |->
        (!o_entry_valid && o_out_stamp == '0 && o_out_data == '0))
        else $error("empty-pop result carries entry contents");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_stamp) &&
        $stable(o_out_data) && $stable(o_status)))
        else $error("stalled output beat changed");

endmodule

bind timestamp_merge_sensor_queues tsmq_checker u_tsmq_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for timestamp_merge_sensor_queues: directed and random push, pop, query and unused-command beats,
// each result checked field by field against an in-bench model of the eight record queues.
// Depends on tsmq_pkg and the RTL of the block; reads no files.

module tb_top;
    import tsmq_pkg::*;

    localparam int SMALL_DEPTH = SMALL_DEPTH_DEF;
    localparam int IMU_DEPTH = IMU_DEPTH_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [DATA_W-1:0] DATA_MAX = '1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                entry_valid;
        logic [SRC_W-1:0]    source;
        logic [STAMP_W-1:0]  stamp;
        logic [DATA_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   high_water;
        logic                first_fix;
    } t_merge_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic                i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command;
    logic [SRC_W-1:0]    i_source;
    logic [FIX_W-1:0]    i_fix_quality;
    logic [STAMP_W-1:0]  i_stamp;
    logic [DATA_W-1:0]   i_record_data;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_entry_valid;
    logic [SRC_W-1:0]    o_out_source;
    logic [STAMP_W-1:0]  o_out_stamp;
    logic [DATA_W-1:0]   o_out_data;
    logic [STATUS_W-1:0] o_status;
    logic [FILL_W-1:0]   o_high_water;
    logic                o_first_fix;

    timestamp_merge_sensor_queues uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_source      (i_source),
        .i_fix_quality (i_fix_quality),
        .i_stamp       (i_stamp),
        .i_record_data (i_record_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_entry_valid (o_entry_valid),
        .o_out_source  (o_out_source),
        .o_out_stamp   (o_out_stamp),
        .o_out_data    (o_out_data),
        .o_status      (o_status),
        .o_high_water  (o_high_water),
        .o_first_fix   (o_first_fix)
    );

    logic [STAMP_W-1:0] q_stamp [NUM_Q][IMU_DEPTH];
    logic [DATA_W-1:0]  q_data [NUM_Q][IMU_DEPTH];
    int                 q_rd [NUM_Q];
    int                 q_wr [NUM_Q];
    int                 q_fill [NUM_Q];
    int                 q_peak [NUM_Q];
    bit                 nav_fix_seen;
    bit                 raw_en;

    t_merge_result merge_results_due [$];
    t_merge_result due_result;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int errors = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int n_popped = 0;
    int n_empty = 0;
    int n_dropped = 0;
    int n_filtered = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic int depth_of(input logic [SRC_W-1:0] src);
        return (src == SRC_IMU) ? IMU_DEPTH : SMALL_DEPTH;
    endfunction

    function automatic t_merge_result merge_predict(
        input logic [CMD_W-1:0]   cmd,
        input logic [SRC_W-1:0]   src,
        input logic [FIX_W-1:0]   fix,
        input logic [STAMP_W-1:0] stamp,
        input logic [DATA_W-1:0]  data
    );
        t_merge_result      r;
        bit                 found;
        logic [SRC_W-1:0]   pick;
        logic [STAMP_W-1:0] best;
        int                 s;
        r = '0;
        found = 1'b0;
        pick = '0;
        best = '0;
        case (cmd)
            CMD_PUSH: begin
                r.source = src;
                if ((src == SRC_NAV && fix != FIX_KEPT) || (src == SRC_RAW && !raw_en)) begin
                    r.status = STAT_FILTER;
                    n_filtered++;
                end else if (q_fill[src] >= depth_of(src)) begin
                    r.status = STAT_DROP;
                    q_peak[src] = depth_of(src);
                    n_dropped++;
                end else begin
                    r.status = STAT_OK;
                    q_stamp[src][q_wr[src]] = stamp;
                    q_data[src][q_wr[src]] = data;
                    q_wr[src] = (q_wr[src] + 1) % depth_of(src);
                    q_fill[src]++;
                    if (q_fill[src] > q_peak[src]) begin
                        q_peak[src] = q_fill[src];
                    end
                end
            end
            CMD_POP: begin
                if (raw_en && q_fill[SRC_RAW] != 0) begin
                    pick = SRC_RAW;
                    found = 1'b1;
                end else if (q_fill[SRC_NAV] != 0) begin
                    pick = SRC_NAV;
                    found = 1'b1;
                end else begin
                    for (s = 0; s < NUM_Q; s++) begin
                        if (s != SRC_NAV && s != SRC_RAW && q_fill[s] != 0) begin
                            if (!found || q_stamp[s][q_rd[s]] < best) begin
                                found = 1'b1;
                                best = q_stamp[s][q_rd[s]];
                                pick = SRC_W'(s);
                            end
                        end
                    end
                end
                if (found) begin
                    r.entry_valid = 1'b1;
                    r.source = pick;
                    r.stamp = q_stamp[pick][q_rd[pick]];
                    r.data = q_data[pick][q_rd[pick]];
                    r.status = STAT_OK;
                    q_rd[pick] = (q_rd[pick] + 1) % depth_of(pick);
                    q_fill[pick]--;
                    if (pick == SRC_NAV && !nav_fix_seen) begin
                        nav_fix_seen = 1'b1;
                        r.first_fix = 1'b1;
                    end
                    n_popped++;
                end else begin
                    r.status = STAT_EMPTY;
                    n_empty++;
                end
            end
            CMD_QUERY: begin
                r.source = src;
                r.high_water = FILL_W'(q_peak[src]);
            end
            default: begin
                r.status = STAT_FILTER;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (merge_results_due.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected: expected none, %s %0d %s %0d",
                         $time, "got source", o_out_source, "status", o_status);
            end else begin
                due_result = merge_results_due.pop_front();
                check_field("entry_valid", due_result.entry_valid, o_entry_valid);
                check_field("out_source", due_result.source, o_out_source);
                check_field("out_stamp", due_result.stamp, o_out_stamp);
                check_field("out_data", due_result.data, o_out_data);
                check_field("status", due_result.status, o_status);
                check_field("high_water", due_result.high_water, o_high_water);
                check_field("first_fix", due_result.first_fix, o_first_fix);
            end
        end
    end

    task automatic send_beat(
        input logic [CMD_W-1:0]   cmd,
        input logic [SRC_W-1:0]   src,
        input logic [FIX_W-1:0]   fix,
        input logic [STAMP_W-1:0] stamp,
        input logic [DATA_W-1:0]  data
    );
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_source <= src;
        i_fix_quality <= fix;
        i_stamp <= stamp;
        i_record_data <= data;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        merge_results_due.push_back(merge_predict(cmd, src, fix, stamp, data));
        beats_sent++;
    endtask

    task automatic settle_phase;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (merge_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_raw(input bit enable);
        settle_phase();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= enable;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        raw_en = enable;
        cfg_writes++;
    endtask

    task automatic send_random(input int push_pct);
        logic [CMD_W-1:0]   cmd;
        logic [SRC_W-1:0]   src;
        logic [FIX_W-1:0]   fix;
        logic [STAMP_W-1:0] stamp;
        int                 roll;
        roll = $urandom_range(99);
        if (roll < push_pct) begin
            cmd = CMD_PUSH;
        end else if (roll < 92) begin
            cmd = CMD_POP;
        end else if (roll < 97) begin
            cmd = CMD_QUERY;
        end else begin
            cmd = CMD_UNUSED;
        end
        src = SRC_W'($urandom_range(7));
        fix = ($urandom_range(3) != 0) ? FIX_KEPT : FIX_W'($urandom_range(7));
        case ($urandom_range(9))
            0: stamp = '0;
            1: stamp = STAMP_MAX;
            2, 3, 4: stamp = STAMP_W'($urandom_range(7));
            default: stamp = $urandom();
        endcase
        send_beat(cmd, src, fix, stamp, {$urandom(), $urandom()});
    endtask

    task automatic test_empty_and_unused;
        set_raw(1'b0);
        send_beat(CMD_POP, SRC_BARO, '0, '0, '0);
        send_beat(CMD_UNUSED, SRC_VBAT, 3'd7, STAMP_MAX, DATA_MAX);
    endtask

    task automatic test_oldest_first;
        send_beat(CMD_PUSH, SRC_BARO, '0, 32'd100, DATA_MAX);
        send_beat(CMD_PUSH, SRC_HUM, '0, 32'd100, '0);
        send_beat(CMD_PUSH, SRC_MAG, '0, STAMP_MAX, {$urandom(), $urandom()});
        send_beat(CMD_PUSH, SRC_TIME, '0, '0, {$urandom(), $urandom()});
        send_beat(CMD_PUSH, SRC_VBAT, '0, 32'd50, {$urandom(), $urandom()});
        repeat (5) send_beat(CMD_POP, SRC_BARO, '0, '0, '0);
    endtask

    task automatic test_nav_filter;
        send_beat(CMD_PUSH, SRC_NAV, 3'd0, 32'd7, {$urandom(), $urandom()});
        send_beat(CMD_PUSH, SRC_NAV, FIX_KEPT, 32'd9, {$urandom(), $urandom()});
        send_beat(CMD_PUSH, SRC_RAW, 3'd7, 32'd1, {$urandom(), $urandom()});
        send_beat(CMD_POP, SRC_BARO, '0, '0, '0);
    endtask

    task automatic test_raw_gate;
        set_raw(1'b1);
        send_beat(CMD_PUSH, SRC_RAW, '0, 32'd3, DATA_MAX);
        send_beat(CMD_PUSH, SRC_NAV, FIX_KEPT, 32'd4, '0);
        set_raw(1'b0);
        send_beat(CMD_POP, SRC_BARO, '0, '0, '0);
        send_beat(CMD_POP, SRC_BARO, '0, '0, '0);
        set_raw(1'b1);
        send_beat(CMD_POP, SRC_BARO, '0, '0, '0);
    endtask

    task automatic test_full_queue;
        repeat (5) send_beat(CMD_PUSH, SRC_HUM, '0, $urandom(), {$urandom(), $urandom()});
        send_beat(CMD_QUERY, SRC_HUM, '0, '0, '0);
    endtask

    task automatic test_imu_fill;
        repeat (IMU_DEPTH + 2) begin
            send_beat(CMD_PUSH, SRC_IMU, FIX_W'($urandom_range(7)), $urandom(),
                      {$urandom(), $urandom()});
        end
        send_beat(CMD_QUERY, SRC_IMU, '0, '0, '0);
        settle_phase();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct,
                                     input int push_pct, input bit enable);
        set_raw(enable);
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random(push_pct);
        settle_phase();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_in_valid = 1'b0;
        i_command = CMD_PUSH;
        i_source = SRC_BARO;
        i_fix_quality = '0;
        i_stamp = '0;
        i_record_data = '0;
        for (int s = 0; s < NUM_Q; s++) begin
            q_rd[s] = 0;
            q_wr[s] = 0;
            q_fill[s] = 0;
            q_peak[s] = 0;
        end
        nav_fix_seen = 1'b0;
        raw_en = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_unused();
        test_oldest_first();
        test_nav_filter();
        test_raw_gate();
        test_full_queue();
        test_imu_fill();
        test_random_phase(105, 0, 0, 55, 1'b1);
        test_random_phase(105, 45, 0, 40, 1'b0);
        test_random_phase(105, 0, 45, 50, 1'b1);
        test_random_phase(105, 14, 14, 35, 1'b0);

        sender_idle_pct = 0;
        recv_stall_pct = 0;
        settle_phase();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d input beats, checked %0d result beats in %0d cycles, %0d %s.",
                 beats_sent, results_checked, cycle_count, cfg_writes, "raw_enable writes");
        $display("Seen: %0d entries popped, %0d empty pops, %0d drops, %0d filtered pushes.",
                 n_popped, n_empty, n_dropped, n_filtered);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
